// ----- rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, constants and helpers of the power-of-two free list allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // default sizing
    localparam int DEF_PAGE_BYTES  = 8192;
    localparam int DEF_MAX_PAGES   = 16;
    localparam int DEF_NUM_CLASSES = 11;

    // fixed field widths
    localparam int ADDR_W = 17;
    localparam int SIZE_W = 14;
    localparam int REG_W  = 14;
    localparam int CNT_W  = 20;
    localparam int GRAN_W = 14;
    localparam int NEED_W = 14;
    localparam int CLS_W  = 4;
    localparam int STAT_W = 2;

    // size classes
    localparam int LARGE_LIMIT = 4096;
    localparam int LARGE_CLASS = 10;
    localparam int MIN_BLOCK   = 8;
    localparam int LINK_BYTES  = 8;

    // config register indexes and reset values
    localparam logic CFG_FIRST_RES = 1'b0;
    localparam logic CFG_PAGE_RES  = 1'b1;
    localparam logic [REG_W-1:0] RST_FIRST_RES = REG_W'(344);
    localparam logic [REG_W-1:0] RST_PAGE_RES  = REG_W'(40);

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_PAGES  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CLASS,
        S_POP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NEWPG,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic do_free;
        logic set_too_large;
        logic open_first;
        logic take_head;
        logic pop;
        logic scan_clear;
        logic scan_next;
        logic scan_take;
        logic add_page;
        logic set_full;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic pages_zero;
        logic too_large;
        logic class_hit;
        logic is_large;
        logic scan_end;
        logic scan_hit;
        logic pages_full;
        logic out_free;
    } t_sts;

    // size class: count of power-of-two steps below size; LARGE_CLASS above 4096
    function automatic logic [CLS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
        logic [CLS_W-1:0] k;
        k = '0;
        if (size > SIZE_W'(LARGE_LIMIT)) begin
            k = CLS_W'(LARGE_CLASS);
        end else begin
            for (int i = 0; i < LARGE_CLASS - 1; i++) begin
                if ((SIZE_W'(MIN_BLOCK) << i) < size) begin
                    k = k + CLS_W'(1);
                end
            end
        end
        return k;
    endfunction

endpackage

// ----- rtl/pow2_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// pow2_free_list_allocator_top
// Power-of-two segregated free list allocator over a paged byte space.
// ----------------------------------------------------------------------------
//  channel   | dir | contents
//  s_axis    | in  | tdata: req_size[13:0], free_addr[30:14]; tuser: req_type
//  m_axis    | out | tdata: grant_addr[16:0]; tuser: status[1:0], released_all[2]
//  cfg       | in  | i_cfg_we, i_cfg_idx (0 first page, 1 later pages), i_cfg_wdata
//
//  A free or a rejected request runs decode and hand-off; a list pop adds the
//  class step and the pop; a bump allocation scans the open pages, one page
//  table read per page, and opens a new page if none fits. One request is in
//  work at a time; the next is taken once the result sits in the output register.
//  Reset is synchronous, active low; the link store and page table need no clear.
//  A stalled m_axis holds the result and the engine waits before its hand-off.
// ----------------------------------------------------------------------------
module pow2_free_list_allocator_top #(
    parameter int PAGE_BYTES  = pfa_pkg::DEF_PAGE_BYTES,
    parameter int MAX_PAGES   = pfa_pkg::DEF_MAX_PAGES,
    parameter int NUM_CLASSES = pfa_pkg::DEF_NUM_CLASSES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,   // req_size, free_addr
    input  logic [0:0]                s_axis_tuser,   // req_type
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [23:0]               m_axis_tdata,   // grant_addr
    output logic [2:0]                m_axis_tuser,   // status, released_all
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [pfa_pkg::REG_W-1:0] i_cfg_wdata
);
    import pfa_pkg::*;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [STAT_W-1:0]  w_status;
    logic [ADDR_W-1:0]  w_grant;
    logic               w_rel;

    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    pfa_datapath #(
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_PAGES   (MAX_PAGES),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (s_axis_tuser[0]),
        .i_req_size     (s_axis_tdata[SIZE_W-1:0]),
        .i_free_addr    (s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (w_status),
        .o_grant_addr   (w_grant),
        .o_released_all (w_rel)
    );

    assign m_axis_tdata = {7'b0, w_grant};
    assign m_axis_tuser = {w_rel, w_status};

endmodule

// ----- rtl/pfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfa_ctrl
// Request sequencer: decode, list pop, page scan, page open, result hand-off.
// ----------------------------------------------------------------------------
module pfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pfa_pkg::t_sts i_sts,
    output pfa_pkg::t_cmd o_cmd
);
    import pfa_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.is_free || i_sts.too_large) n_state = S_DONE;
                else n_state = S_CLASS;
            end
            S_CLASS: begin
                if (i_sts.class_hit) n_state = S_POP;
                else if (i_sts.is_large) n_state = S_NEWPG;
                else n_state = S_SCAN_RD;
            end
            S_POP: n_state = S_DONE;
            S_SCAN_RD: begin
                if (i_sts.scan_end) n_state = S_NEWPG;
                else n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.scan_hit) n_state = S_DONE;
                else n_state = S_SCAN_RD;
            end
            S_NEWPG: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load_req = i_valid;
            end
            S_DECODE: begin
                if (i_sts.is_free) begin
                    o_cmd.do_free = !i_sts.pages_zero;
                end else if (i_sts.too_large) begin
                    o_cmd.set_too_large = 1'b1;
                end else begin
                    o_cmd.open_first = i_sts.pages_zero;
                end
            end
            S_CLASS: begin
                o_cmd.take_head  = i_sts.class_hit;
                o_cmd.scan_clear = !i_sts.class_hit;
            end
            S_POP: o_cmd.pop = 1'b1;
            S_SCAN_RD: ;
            S_SCAN_CHK: begin
                o_cmd.scan_take = i_sts.scan_hit;
                o_cmd.scan_next = !i_sts.scan_hit;
            end
            S_NEWPG: begin
                o_cmd.set_full = i_sts.pages_full;
                o_cmd.add_page = !i_sts.pages_full;
            end
            S_DONE: o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ----- rtl/pfa_datapath.sv -----
// ----------------------------------------------------------------------------
// pfa_datapath
// Request registers, class heads, link store, page table and result register.
// ----------------------------------------------------------------------------
module pfa_datapath #(
    parameter int PAGE_BYTES  = pfa_pkg::DEF_PAGE_BYTES,
    parameter int MAX_PAGES   = pfa_pkg::DEF_MAX_PAGES,
    parameter int NUM_CLASSES = pfa_pkg::DEF_NUM_CLASSES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfa_pkg::t_cmd               i_cmd,
    output pfa_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pfa_pkg::REG_W-1:0]   i_cfg_wdata,
    input  logic                        i_req_type,
    input  logic [pfa_pkg::SIZE_W-1:0]  i_req_size,
    input  logic [pfa_pkg::ADDR_W-1:0]  i_free_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pfa_pkg::STAT_W-1:0]  o_status,
    output logic [pfa_pkg::ADDR_W-1:0]  o_grant_addr,
    output logic                        o_released_all
);
    import pfa_pkg::*;

    localparam int PG_W = $clog2(PAGE_BYTES + 1);
    localparam int PN_W = $clog2(MAX_PAGES + 1);
    localparam int PI_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CL_W = $clog2(NUM_CLASSES);
    localparam int LINK_DEPTH = 1 << GRAN_W;

    // request and config
    logic                 r_type;
    logic [SIZE_W-1:0]    r_size;
    logic [ADDR_W-1:0]    r_faddr;
    logic [REG_W-1:0]     r_first_res;
    logic [REG_W-1:0]     r_page_res;

    // allocator state
    logic [ADDR_W-1:0]    r_head [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_cvalid;
    logic [PN_W-1:0]      r_pages;
    logic [CNT_W-1:0]     r_acnt;
    logic [CNT_W-1:0]     r_fcnt;
    logic [PN_W-1:0]      r_scan;
    logic [ADDR_W-1:0]    r_addr;

    // memories
    logic [PG_W-1:0]      pf_mem [MAX_PAGES];
    logic [PG_W-1:0]      r_pf_rd;
    logic [ADDR_W:0]      link_mem [LINK_DEPTH];
    logic [ADDR_W:0]      r_link_rd;

    // result
    t_status              r_status;
    logic [ADDR_W-1:0]    r_grant;
    logic                 r_rel;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [ADDR_W-1:0]    r_out_grant;
    logic                 r_out_rel;

    logic [CL_W-1:0]      w_cls;
    logic [NEED_W-1:0]    w_need;
    logic                 w_large;
    logic                 w_too_large;
    logic [ADDR_W-1:0]    w_head;
    logic                 w_hvalid;
    logic [CNT_W-1:0]     w_fcnt_inc;
    logic [31:0]          w_first32;
    logic [31:0]          w_page32;
    logic [PG_W-1:0]      w_init_first;
    logic [31:0]          w_init_page;
    logic [31:0]          w_min_res;
    logic [31:0]          w_new_base;
    logic [31:0]          w_scan_base;
    logic [ADDR_W-1:0]    w_new_addr;
    logic [ADDR_W-1:0]    w_scan_addr;
    logic [PG_W-1:0]      w_new_free;
    logic                 w_hit;
    logic                 w_pf_we;
    logic [PI_W-1:0]      w_pf_waddr;
    logic [PG_W-1:0]      w_pf_wdata;

    // decode of the held request
    always_comb begin
        w_cls       = CL_W'(class_of(r_size));
        w_need      = NEED_W'(MIN_BLOCK) << class_of(r_size);
        w_large     = r_size > SIZE_W'(LARGE_LIMIT);
        w_too_large = (32'(r_size) + 32'(LINK_BYTES)) > 32'(PAGE_BYTES);
        w_head      = r_head[w_cls];
        w_hvalid    = r_cvalid[w_cls];
        w_fcnt_inc  = r_fcnt + CNT_W'(1);
    end

    // page arithmetic
    always_comb begin
        w_first32    = 32'(r_first_res);
        w_page32     = 32'(r_page_res);
        w_init_first = (w_first32 >= 32'(PAGE_BYTES)) ? '0
                     : PG_W'(32'(PAGE_BYTES) - w_first32);
        w_init_page  = (w_page32 >= 32'(PAGE_BYTES)) ? '0
                     : 32'(PAGE_BYTES) - w_page32;
        w_min_res    = (w_page32 >= 32'(PAGE_BYTES)) ? 32'(PAGE_BYTES) : w_page32;
        w_new_base   = 32'(r_pages) * 32'(PAGE_BYTES);
        w_scan_base  = 32'(r_scan) * 32'(PAGE_BYTES);
        w_new_addr   = ADDR_W'(w_new_base + w_min_res);
        w_scan_addr  = ADDR_W'(w_scan_base + 32'(PAGE_BYTES) - 32'(r_pf_rd));
        w_hit        = 32'(r_pf_rd) > 32'(w_need);
        if (w_large || w_init_page <= 32'(w_need)) w_new_free = '0;
        else w_new_free = PG_W'(w_init_page - 32'(w_need));
    end

    // page table write port
    always_comb begin
        w_pf_we    = 1'b0;
        w_pf_waddr = '0;
        w_pf_wdata = w_init_first;
        if (i_cmd.open_first) begin
            w_pf_we = 1'b1;
        end else if (i_cmd.scan_take) begin
            w_pf_we    = 1'b1;
            w_pf_waddr = r_scan[PI_W-1:0];
            w_pf_wdata = r_pf_rd - PG_W'(w_need);
        end else if (i_cmd.add_page) begin
            w_pf_we    = 1'b1;
            w_pf_waddr = r_pages[PI_W-1:0];
            w_pf_wdata = w_new_free;
        end
    end

    // status to controller
    always_comb begin
        o_sts.is_free    = r_type;
        o_sts.pages_zero = (r_pages == '0);
        o_sts.too_large  = w_too_large;
        o_sts.class_hit  = w_hvalid;
        o_sts.is_large   = w_large;
        o_sts.scan_end   = (r_scan >= r_pages);
        o_sts.scan_hit   = w_hit;
        o_sts.pages_full = (r_pages >= PN_W'(MAX_PAGES));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // page free bytes memory
    always_ff @(posedge i_clk) begin
        if (w_pf_we) pf_mem[w_pf_waddr] <= w_pf_wdata;
        r_pf_rd <= pf_mem[r_scan[PI_W-1:0]];
    end

    // link store: {valid, next head} per 8-byte granule
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_free) link_mem[r_faddr[ADDR_W-1:3]] <= {w_hvalid, w_head};
        r_link_rd <= link_mem[w_head[ADDR_W-1:3]];
    end

    // class heads (payload)
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_free) r_head[w_cls] <= r_faddr;
        else if (i_cmd.pop) r_head[w_cls] <= r_link_rd[ADDR_W-1:0];
    end

    // request and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type   <= i_req_type;
            r_size   <= i_req_size;
            r_faddr  <= i_free_addr;
            r_status <= ST_OK;
            r_grant  <= '0;
            r_rel    <= 1'b0;
        end
        if (i_cmd.take_head) r_addr <= w_head;
        if (i_cmd.set_too_large) r_status <= ST_TOO_LARGE;
        if (i_cmd.set_full) r_status <= ST_NO_PAGES;
        if (i_cmd.pop) r_grant <= r_addr;
        if (i_cmd.scan_take) r_grant <= w_scan_addr;
        if (i_cmd.add_page) r_grant <= w_new_addr;
        if (i_cmd.do_free && w_fcnt_inc == r_acnt) r_rel <= 1'b1;
        if (i_cmd.scan_clear) r_scan <= '0;
        else if (i_cmd.scan_next) r_scan <= r_scan + PN_W'(1);
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_grant  <= r_grant;
            r_out_rel    <= r_rel;
        end
    end

    // control state: config, pages, counts, list valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_res <= RST_FIRST_RES;
            r_page_res  <= RST_PAGE_RES;
            r_pages     <= '0;
            r_acnt      <= '0;
            r_fcnt      <= '0;
            r_cvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIRST_RES) r_first_res <= i_cfg_wdata;
                else r_page_res <= i_cfg_wdata;
            end
            if (i_cmd.do_free) begin
                if (w_fcnt_inc == r_acnt) begin
                    r_pages  <= '0;
                    r_cvalid <= '0;
                    r_acnt   <= '0;
                    r_fcnt   <= '0;
                end else begin
                    r_cvalid[w_cls] <= 1'b1;
                    r_fcnt          <= w_fcnt_inc;
                end
            end
            if (i_cmd.open_first) begin
                r_pages  <= PN_W'(1);
                r_cvalid <= '0;
            end
            if (i_cmd.pop) r_cvalid[w_cls] <= r_link_rd[ADDR_W];
            if (i_cmd.add_page) r_pages <= r_pages + PN_W'(1);
            if (i_cmd.pop || i_cmd.scan_take || i_cmd.add_page) begin
                r_acnt <= r_acnt + CNT_W'(1);
            end
            if (i_cmd.load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_grant_addr   = r_out_grant;
    assign o_released_all = r_out_rel;

endmodule

// ----- sim/pow2_free_list_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// pow2_free_list_allocator_top_tb
// Self-checking bench for the power-of-two free list allocator. Requests go
// in on s_axis with random gaps and results come back on m_axis with random
// stalls. A behavioral model tracks class lists, the link store and page
// table, predicts every result word, and each result is compared in order.
// ----------------------------------------------------------------------------
module pow2_free_list_allocator_top_tb;
    import pfa_pkg::*;

    localparam int PG_BYTES   = 8192;
    localparam int PG_MAX     = 16;
    localparam int CLS_NUM    = 11;
    localparam int GRANS      = 16384;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 60;
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        t_status          status;
        logic [ADDR_W-1:0] grant;
        logic             rel;
    } t_alloc_result;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // DUT ports
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;    // req_size[13:0], free_addr[30:14]
    logic [0:0]        s_axis_tuser = '0;    // req_type
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;         // grant_addr[16:0]
    logic [2:0]        m_axis_tuser;         // status[1:0], released_all[2]
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = 1'b0;
    logic [REG_W-1:0]  i_cfg_wdata = '0;

    pow2_free_list_allocator_top dut (.*);

    // allocator model state
    int unsigned        res_first, res_later;
    logic [ADDR_W-1:0]  head [CLS_NUM];
    bit                 head_ok [CLS_NUM];
    logic [ADDR_W-1:0]  link_mem [GRANS];
    bit                 link_ok [GRANS];
    int unsigned        pg_free [PG_MAX];
    int unsigned        pg_open;
    logic [CNT_W-1:0]   n_alloc, n_free;

    t_alloc_result      pending_results [$];
    int unsigned        live_addr [$];
    int unsigned        live_size [$];

    int fail_count = 0;
    int n_sent = 0, n_checked = 0, n_release = 0, n_nopage = 0, n_toolarge = 0;
    bit sender_busy_mode = 1'b0;     // no gaps
    bit sink_busy_mode = 1'b0;       // no stalls

    function automatic int unsigned size_class(int unsigned size);
        int unsigned k;
        k = 0;
        if (size > 4096) return 10;
        while (k < 9 && (8 << k) < size) k++;
        return k;
    endfunction

    function automatic int unsigned fresh_bytes(int unsigned reserved);
        return (reserved >= PG_BYTES) ? 0 : PG_BYTES - reserved;
    endfunction

    function automatic void drop_lists();
        for (int i = 0; i < CLS_NUM; i++) begin
            head[i] = '0;
            head_ok[i] = 1'b0;
        end
    endfunction

    // compute the result of one request and advance the model
    function automatic t_alloc_result allocate_or_free(logic kind, int unsigned size,
                                                       int unsigned addr);
        t_alloc_result r;
        int unsigned cls, g, need, a, init;
        bit ok, big;
        r = '{ST_OK, '0, 1'b0};
        if (kind == REQ_FREE) begin
            if (pg_open == 0) return r;
            cls = size_class(size);
            g = (addr >> 3) % GRANS;
            link_mem[g] = head[cls];
            link_ok[g] = head_ok[cls];
            head[cls] = addr;
            head_ok[cls] = 1'b1;
            n_free = n_free + 1'b1;
            if (n_free == n_alloc) begin
                pg_open = 0;
                drop_lists();
                n_alloc = '0;
                n_free = '0;
                r.rel = 1'b1;
            end
            return r;
        end
        if (size + 8 > PG_BYTES) begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        if (pg_open == 0) begin
            pg_free[0] = fresh_bytes(res_first);
            pg_open = 1;
            drop_lists();
        end
        cls = size_class(size);
        ok = 1'b0;
        a = 0;
        if (head_ok[cls]) begin
            a = head[cls];
            g = (a >> 3) % GRANS;
            head[cls] = link_mem[g];
            head_ok[cls] = link_ok[g];
            ok = 1'b1;
        end else begin
            need = 8 << cls;
            big = size > 4096;
            if (!big) begin
                for (int p = 0; p < pg_open && p < PG_MAX; p++) begin
                    if (!ok && pg_free[p] > need) begin
                        a = p * PG_BYTES + PG_BYTES - pg_free[p];
                        pg_free[p] -= need;
                        ok = 1'b1;
                    end
                end
            end
            if (!ok) begin
                if (pg_open >= PG_MAX) begin
                    r.status = ST_NO_PAGES;
                end else begin
                    init = fresh_bytes(res_later);
                    a = pg_open * PG_BYTES + PG_BYTES - init;
                    pg_free[pg_open] = big ? 0 : (init > need ? init - need : 0);
                    pg_open++;
                    ok = 1'b1;
                end
            end
        end
        if (ok) begin
            n_alloc = n_alloc + 1'b1;
            r.grant = a[ADDR_W-1:0];
        end
        return r;
    endfunction

    // send one request word; valid stays high on return
    task automatic send_req(logic kind, int unsigned size, int unsigned addr);
        int gap;
        t_alloc_result r;
        gap = sender_busy_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {1'b0, addr[ADDR_W-1:0], size[SIZE_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        r = allocate_or_free(kind, size, addr);
        pending_results.push_back(r);
        n_sent++;
        if (r.rel) begin
            n_release++;
            live_addr.delete();
            live_size.delete();
        end
        if (r.status == ST_NO_PAGES) n_nopage++;
        if (r.status == ST_TOO_LARGE) n_toolarge++;
        if (kind == REQ_ALLOC && r.status == ST_OK) begin
            live_addr.push_back(r.grant);
            live_size.push_back(size);
        end
    endtask

    // stop sending and wait until every result is back and the engine is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value[REG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FIRST_RES) res_first = value;
        else res_later = value;
    endtask

    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 64);
        if (r < 80) return $urandom_range(65, 512);
        if (r < 90) return $urandom_range(513, 4096);
        if (r < 97) return $urandom_range(4097, 8184);
        return $urandom_range(8185, 8192);
    endfunction

    // one random request: mostly allocs and frees of live blocks, some noise
    task automatic random_req();
        int r, i;
        int unsigned a, s;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            send_req(REQ_FREE, $urandom_range(0, 8192), $urandom_range(0, 131071));
        end else if (r < 58 || live_addr.size() == 0) begin
            send_req(REQ_ALLOC, pick_size(), $urandom_range(0, 131071));
        end else begin
            i = $urandom_range(0, live_addr.size() - 1);
            a = live_addr[i];
            s = live_size[i];
            live_addr.delete(i);
            live_size.delete(i);
            send_req(REQ_FREE, s, a);
        end
    endtask

    // result checker and sink stall control
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            n_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word tdata=%h tuser=%h",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[1:0] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser[1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[ADDR_W-1:0] !== want.grant) begin
                    $display("%0t: grant_addr expected %h actual %h",
                             $time, want.grant, m_axis_tdata[ADDR_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tuser[2] !== want.rel) begin
                    $display("%0t: released_all expected %0b actual %0b",
                             $time, want.rel, m_axis_tuser[2]);
                    fail_count++;
                end
            end
            stall_left = sink_busy_mode ? 0 : $urandom_range(0, 10);
            if (stall_left != 0) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (stall_left == 0) m_axis_tready <= 1'b1;
            else stall_left--;
        end
    end

    // watchdog on cycles with no word moving
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("pow2_free_list_allocator_top_tb: FAIL");
            $finish;
        end
    end

    // edge cases: idle free, size boundaries, list reuse, page exhaustion, release
    task automatic test_directed();
        int unsigned fa, fs;
        send_req(REQ_FREE, 16, 1024);              // no page open: ignored
        send_req(REQ_ALLOC, 0, 0);
        send_req(REQ_ALLOC, 8, 0);
        send_req(REQ_ALLOC, 9, 0);
        send_req(REQ_ALLOC, 4096, 0);
        send_req(REQ_ALLOC, 8184, 0);
        send_req(REQ_ALLOC, 8185, 0);              // too large
        send_req(REQ_ALLOC, 8192, 0);              // too large, top size bit
        send_req(REQ_FREE, 9, live_addr[2]);
        send_req(REQ_ALLOC, 12, 0);                // pops the freed block
        repeat (16) send_req(REQ_ALLOC, 4097, 0);  // runs out of pages
        send_req(REQ_ALLOC, 3000, 0);
        drain();
        while (live_addr.size() != 0) begin
            fa = live_addr.pop_front();
            fs = live_size.pop_front();
            send_req(REQ_FREE, fs, fa);
        end
        drain();
    endtask

    // header sizes at the extremes and in between
    task automatic test_reserved_sweep();
        int unsigned first_v [4] = '{0, 8192, 8191, 0};
        int unsigned later_v [4] = '{8192, 0, 4096, 7};
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            if (ph < 4) begin
                write_reg(CFG_FIRST_RES, first_v[ph]);
                write_reg(CFG_PAGE_RES, later_v[ph]);
            end else begin
                write_reg(CFG_FIRST_RES, $urandom_range(0, 8192));
                write_reg(CFG_PAGE_RES, $urandom_range(0, 8192));
            end
            repeat (40) random_req();
        end
        drain();
        write_reg(CFG_FIRST_RES, 344);
        write_reg(CFG_PAGE_RES, 40);
    endtask

    // long random mix with changing gap and stall patterns
    task automatic test_random_mix();
        for (int blk = 0; blk < 10; blk++) begin
            sender_busy_mode = (blk % 4) == 1;
            sink_busy_mode = (blk % 3) == 2;
            repeat (100) random_req();
            if (blk == 4) drain();               // hold off until all results are in
        end
        sender_busy_mode = 1'b0;
        sink_busy_mode = 1'b0;
        drain();
    endtask

    initial begin
        res_first = 344;
        res_later = 40;
        pg_open = 0;
        n_alloc = '0;
        n_free = '0;
        drop_lists();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_reserved_sweep();
        test_random_mix();
        $display("Run: %0d requests, %0d results checked, %0d releases,",
                 n_sent, n_checked, n_release);
        $display("     %0d out-of-page and %0d oversize answers, 6 header settings.",
                 n_nopage, n_toolarge);
        if (fail_count == 0)
            $display("pow2_free_list_allocator_top_tb: PASS");
        else
            $display("pow2_free_list_allocator_top_tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pfa_pkg.sv
rtl/pfa_ctrl.sv
rtl/pfa_datapath.sv
rtl/pow2_free_list_allocator_top.sv
sim/pow2_free_list_allocator_top_tb.sv
